### rtl/gfau_pkg.sv
// Package for the GF(2^8) arithmetic unit: transaction types, op codes, field functions.
package gfau_pkg;

    // Field parameters: x^8+x^4+x^3+x+1, low part of the reduction polynomial
    localparam logic [7:0] GF_REDUCE_LOW = 8'h1B;
    localparam int         GF_SIZE       = 256;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_gf_op;

    // Input transaction
    typedef struct packed {
        t_gf_op      op;
        logic [7:0]  operand_a;
        logic [7:0]  operand_b;
    } t_gfau_in;

    // Result transaction
    typedef struct packed {
        logic [7:0]  result;
        logic        div_by_zero;
    } t_gfau_out;

    typedef logic [GF_SIZE-1:0][7:0] t_gf_table;

    // Multiply by x with reduction
    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        logic [7:0] r;
        r = {a[6:0], 1'b0};
        if (a[7]) begin
            r = r ^ GF_REDUCE_LOW;
        end
        return r;
    endfunction

    // Shift-and-add field multiply, eight narrow steps
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] aa;
        acc = 8'h00;
        aa  = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ aa;
            end
            aa = gf_xtime(aa);
        end
        return acc;
    endfunction

    // Inverse table built at elaboration; entry zero maps to zero
    function automatic t_gf_table gf_build_inv();
        t_gf_table tab;
        for (int x = 0; x < GF_SIZE; x++) begin
            tab[x] = 8'h00;
        end
        for (int x = 1; x < GF_SIZE; x++) begin
            for (int y = 1; y < GF_SIZE; y++) begin
                if (gf_mul(8'(x), 8'(y)) == 8'h01) begin
                    tab[x] = 8'(y);
                end
            end
        end
        return tab;
    endfunction

    localparam t_gf_table GF_INV_TABLE = gf_build_inv();

endpackage

### rtl/gfau_in_reg.sv
// Input register stage of the GF(2^8) arithmetic unit.
module gfau_in_reg
    import gfau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_gfau_in  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_gfau_in  o_data
);

    logic     r_valid;
    logic     n_valid;
    t_gfau_in r_data;

    // Stage can take a new transaction when empty or draining this cycle
    assign o_ready = !r_valid || i_ready;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/gfau_datapath.sv
// Combinational field operation: add/sub, multiply, divide via inverse table.
module gfau_datapath
    import gfau_pkg::*;
(
    input  t_gfau_in  i_data,
    output t_gfau_out o_data
);

    logic [7:0] b_inv;
    logic [7:0] mul_rhs;
    logic [7:0] product;
    logic       dz;

    // Inverse of zero reads as zero, so divide by zero yields 0 naturally
    assign b_inv   = GF_INV_TABLE[i_data.operand_b];
    assign mul_rhs = (i_data.op == OP_DIV) ? b_inv : i_data.operand_b;
    assign product = gf_mul(i_data.operand_a, mul_rhs);

    // Flag only a nonzero dividend over a zero divisor
    assign dz = (i_data.op == OP_DIV) && (i_data.operand_a != 8'h00)
                && (i_data.operand_b == 8'h00);

    always_comb begin
        o_data.div_by_zero = dz;
        unique case (i_data.op)
            OP_ADD, OP_SUB: o_data.result = i_data.operand_a ^ i_data.operand_b;
            OP_MUL, OP_DIV: o_data.result = product;
            default:        o_data.result = 8'h00;
        endcase
    end

endmodule

### rtl/gfau_out_reg.sv
// Result register stage of the GF(2^8) arithmetic unit.
module gfau_out_reg
    import gfau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_gfau_out i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_gfau_out o_data
);

    logic      r_valid;
    logic      n_valid;
    t_gfau_out r_data;

    // Load when empty or when the held result is taken this cycle
    assign o_ready = !r_valid || i_ready;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/gf256_arith_unit.sv
// Top level of the GF(2^8) arithmetic unit (polynomial 0x11B).
//
// Usage:
//   Input channel  i_in_valid / o_in_ready / i_in_data carries one operation
//   (add, subtract, multiply, divide) and two byte operands per transaction.
//   Output channel o_out_valid / i_out_ready / o_out_data returns one result
//   byte and a divide-by-zero flag per input transaction, in order.
//   Path: a transaction accepted on the input channel is captured in the input
//   register, computed in one pass of combinational logic (inverse table
//   lookup, then an 8-step shift-and-add multiply) and loaded into the result
//   register, whose valid bit drives o_out_valid.
//   Throughput: one transaction per cycle while i_out_ready stays high, set
//   by the single-pass datapath between the two registers.
//   Stall: when i_out_ready is low the result register holds its transaction;
//   the input register still takes one more, then o_in_ready drops until the
//   result is taken. Ready passes back combinationally through both stages.
//   Reset: synchronous, active low; both stages are emptied. The unit keeps
//   no other state.
module gf256_arith_unit
    import gfau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_gfau_in  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_gfau_out o_out_data
);

    logic      stg_valid;
    logic      stg_ready;
    t_gfau_in  stg_data;
    t_gfau_out calc_data;

    // Input register
    gfau_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (stg_valid),
        .i_ready (stg_ready),
        .o_data  (stg_data)
    );

    // Field operation
    gfau_datapath u_datapath (
        .i_data (stg_data),
        .o_data (calc_data)
    );

    // Result register
    gfau_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid),
        .o_ready (stg_ready),
        .i_data  (calc_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    // A flagged division always reports a zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.div_by_zero |-> o_out_data.result == 8'h00)
        else $error("div_by_zero set with nonzero result");

    // Only a divide transaction can raise the flag
    a_dz_div_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stg_valid && stg_ready && stg_data.op != OP_DIV |=> !o_out_data.div_by_zero)
        else $error("div_by_zero raised by a non-divide op");

    // A new result appears only when the input register held a transaction
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(stg_valid))
        else $error("result appeared without a staged transaction");

    // Input backpressure only when both stages are full
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> stg_valid && o_out_valid && !i_out_ready)
        else $error("input stalled while pipeline had room");

    // Reset empties both stages
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !stg_valid && !o_out_valid)
        else $error("pipeline not empty after reset");

endmodule

### dv/tb_gf256_arith_unit.sv
// Self-checking testbench for the GF(2^8) arithmetic unit with random stalls on both channels.
`timescale 1ns / 1ps

module tb_gf256_arith_unit;
    import gfau_pkg::*;

    localparam int  CLK_PERIOD   = 20;
    localparam int  RESET_CYCLES = 9;
    localparam int  LONG_HOLD    = 80;
    localparam int  FLOOD_ITEMS  = 40;
    localparam int  RANDOM_ITEMS = 880;
    localparam int  STEADY_ITEMS = 100;
    localparam int  TAIL_CYCLES  = 6;
    localparam int  CYCLE_LIMIT  = 300000;

    // Expected results of field operations, oldest first
    class gf_result_board;
        t_gfau_out expected_q[$];
        int        errors;
        int        op_count[4];
        int        dz_count;

        // Horner-style carry-less multiply, reduced by x^8+x^4+x^3+x+1
        static function logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
            logic [7:0] acc;
            acc = 8'h00;
            for (int i = 7; i >= 0; i--) begin
                acc = {acc[6:0], 1'b0} ^ (acc[7] ? GF_REDUCE_LOW : 8'h00);
                if (b[i]) begin
                    acc = acc ^ a;
                end
            end
            return acc;
        endfunction

        function t_gfau_out field_result(t_gfau_in item);
            t_gfau_out  res;
            logic [7:0] inv;
            logic [7:0] pw;
            res = '0;
            case (item.op)
                OP_ADD, OP_SUB: begin
                    res.result = item.operand_a ^ item.operand_b;
                end
                OP_MUL: begin
                    res.result = field_mul(item.operand_a, item.operand_b);
                end
                default: begin
                    if (item.operand_a == 8'h00) begin
                        res.result = 8'h00;
                    end else if (item.operand_b == 8'h00) begin
                        res.div_by_zero = 1'b1;
                    end else begin
                        // inverse is b^254 = b^2 * b^4 * ... * b^128
                        inv = 8'h01;
                        pw  = item.operand_b;
                        for (int k = 1; k < 8; k++) begin
                            pw  = field_mul(pw, pw);
                            inv = field_mul(inv, pw);
                        end
                        res.result = field_mul(item.operand_a, inv);
                    end
                end
            endcase
            return res;
        endfunction

        function void note_operation(t_gfau_in item);
            t_gfau_out res;
            res = field_result(item);
            op_count[item.op]++;
            if (res.div_by_zero) begin
                dz_count++;
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(t_gfau_out got);
            t_gfau_out want;
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction: result %h div_by_zero %b",
                       got.result, got.div_by_zero);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.result !== want.result) begin
                $error("result: expected %h, got %h", want.result, got.result);
                errors++;
            end
            if (got.div_by_zero !== want.div_by_zero) begin
                $error("div_by_zero: expected %b, got %b", want.div_by_zero, got.div_by_zero);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_gfau_in  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_gfau_out o_out_data;

    gf_result_board board = new;

    bit hold_req;
    bit no_idle;
    int cycle_count;

    gf256_arith_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever begin
            #(CLK_PERIOD / 2) i_clk = ~i_clk;
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, board.pending());
        $display("end of test: mismatches");
        $finish;
    end

    // Transaction monitors, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            board.note_operation(i_in_data);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result(o_out_data);
        end
    end

    // Result sink: random stall bursts, plus one long hold on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end else if (no_idle) begin
                stall_left = 0;
            end else if (stall_left == 0 && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offer one transaction, optionally after a random gap; returns at a falling edge
    task automatic send_item(input t_gfau_in item, input bit allow_gap);
        int gap;
        if (allow_gap && !no_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Operands lean toward zero, one and all-ones
    function automatic logic [7:0] pick_operand();
        case ($urandom_range(0, 15))
            0, 1:    return 8'h00;
            2:       return 8'h01;
            3:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_gfau_in random_item();
        t_gfau_in item;
        item.op        = t_gf_op'($urandom_range(0, 3));
        item.operand_a = pick_operand();
        item.operand_b = pick_operand();
        return item;
    endfunction

    initial begin
        t_gfau_in directed_q[$];
        hold_req    = 1'b0;
        no_idle     = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, every op, zero operands and divide by zero
        directed_q.push_back('{OP_ADD, 8'h00, 8'h00});
        directed_q.push_back('{OP_ADD, 8'hFF, 8'h00});
        directed_q.push_back('{OP_ADD, 8'hFF, 8'hFF});
        directed_q.push_back('{OP_SUB, 8'hA5, 8'h5A});
        directed_q.push_back('{OP_SUB, 8'h00, 8'hFF});
        directed_q.push_back('{OP_MUL, 8'h00, 8'hFF});
        directed_q.push_back('{OP_MUL, 8'hFF, 8'h00});
        directed_q.push_back('{OP_MUL, 8'h00, 8'h00});
        directed_q.push_back('{OP_MUL, 8'h01, 8'hFF});
        directed_q.push_back('{OP_MUL, 8'hFF, 8'hFF});
        directed_q.push_back('{OP_MUL, 8'h80, 8'h02});
        directed_q.push_back('{OP_MUL, 8'h57, 8'h83});
        directed_q.push_back('{OP_MUL, 8'h03, 8'h03});
        directed_q.push_back('{OP_DIV, 8'h00, 8'h00});
        directed_q.push_back('{OP_DIV, 8'h00, 8'h37});
        directed_q.push_back('{OP_DIV, 8'h05, 8'h00});
        directed_q.push_back('{OP_DIV, 8'hFF, 8'h00});
        directed_q.push_back('{OP_DIV, 8'h01, 8'h01});
        directed_q.push_back('{OP_DIV, 8'h01, 8'hFF});
        directed_q.push_back('{OP_DIV, 8'hFF, 8'hFF});
        directed_q.push_back('{OP_DIV, 8'hC1, 8'h83});
        directed_q.push_back('{OP_DIV, 8'h80, 8'h53});
        foreach (directed_q[i]) begin
            send_item(directed_q[i], 1'b1);
        end
        drain();

        // Hold the sink off while the source keeps offering, so the unit backs up
        hold_req = 1'b1;
        repeat (FLOOD_ITEMS) send_item(random_item(), 1'b0);
        drain();

        // Random traffic with idle bursts on both sides
        repeat (RANDOM_ITEMS) send_item(random_item(), 1'b1);

        // Back-to-back traffic with no idling
        no_idle = 1'b1;
        repeat (STEADY_ITEMS) send_item(random_item(), 1'b1);
        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (board.pending() != 0) begin
            $error("%0d expected results never arrived", board.pending());
            board.errors++;
        end
        $display("ran %0d add, %0d sub, %0d mul, %0d div transactions",
                 board.op_count[OP_ADD], board.op_count[OP_SUB],
                 board.op_count[OP_MUL], board.op_count[OP_DIV]);
        $display("%0d divides by zero, one long output stall, %0d cycles",
                 board.dz_count, cycle_count);
        if (board.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
